// File: design/tde_pkg.sv
// ----------------------------------------------------------------------------
// tde_pkg: shared definitions for the trie dictionary engine
// Field widths of the item and result beats, operation and status codes.
// ----------------------------------------------------------------------------
package tde_pkg;

    // Item and result field widths
    localparam int OP_W     = 2;
    localparam int LETTER_W = 5;

    // Operation codes; the unused code behaves as a search
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_POOL_FULL = 1'b1;

endpackage

// File: design/tde_if.sv
// ----------------------------------------------------------------------------
// tde_if: item and result channels of the trie dictionary engine
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface tde_item_if
    import tde_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [LETTER_W-1:0] letter;
    logic                no_letter;
    logic                is_last;

    modport source (output valid, output op, output letter, output no_letter,
                    output is_last, input ready);
    modport sink   (input valid, input op, input letter, input no_letter,
                    input is_last, output ready);
endinterface

interface tde_result_if
    import tde_pkg::*;
();
    logic valid;
    logic ready;
    logic answer;
    logic status;

    modport source (output valid, output answer, output status, input ready);
    modport sink   (input valid, input answer, input status, output ready);
endinterface

// File: design/tde_node_ram.sv
// ----------------------------------------------------------------------------
// tde_node_ram: node row memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tde_node_ram
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 286
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/trie_dictionary_engine.sv
// Sequence: an item beat is taken in S_IDLE with the row read of the cursor node
//   (or of the row with its mark), then S_EXEC does the row update; a word's
//   result enters the output register from S_EXEC, or later from S_HOLD while
//   the result side stalls. Each item beat waits for the previous row update.
// Reset: a clearing pass writes all NODE_COUNT rows, one per cycle, with item
//   ready low; the cursor returns to the root and node 1 is the next free node.
// ----------------------------------------------------------------------------
// trie_dictionary_engine: letter trie insert, search and delete
// Each node row holds the child links of all letters plus the word-end marks
// of those children; the root's own mark lives in a flip-flop.
// ----------------------------------------------------------------------------
module trie_dictionary_engine
    import tde_pkg::*;
#(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26
)
(
    input  logic                clk,
    input  logic                rst_n,
    tde_item_if.sink            items,
    tde_result_if.source        results
);

    localparam int NW  = $clog2(NODE_COUNT);
    localparam int NFW = $clog2(NODE_COUNT + 1);
    localparam int LW  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    typedef struct packed {
        logic [ALPHABET_SIZE-1:0]         marks;
        logic [ALPHABET_SIZE-1:0][NW-1:0] links;
    } node_row_t;

    localparam int ROW_W = $bits(node_row_t);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_HOLD
    } state_t;

    state_t              state_reg, state_next;
    logic [NW-1:0]       clr_reg, clr_next;
    logic [NFW-1:0]      nf_reg, nf_next;
    logic [NW-1:0]       cursor_reg, cursor_next;
    logic                at_root_reg, at_root_next;
    logic [NW-1:0]       mrow_reg, mrow_next;
    logic [LW-1:0]       mlet_reg, mlet_next;
    logic                miss_reg, miss_next;
    logic                ovf_reg, ovf_next;
    logic                root_mark_reg, root_mark_next;

    logic [OP_W-1:0]     op_reg, op_next;
    logic [LETTER_W-1:0] letter_reg, letter_next;
    logic                nl_reg, nl_next;
    logic                last_reg, last_next;
    logic [NW-1:0]       row_addr_reg, row_addr_next;

    logic                pend_answer_reg, pend_answer_next;
    logic                pend_status_reg, pend_status_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_answer_reg, out_answer_next;
    logic                out_status_reg, out_status_next;

    logic                accept;
    logic                out_free;
    logic [NW-1:0]       rd_addr;
    logic [ROW_W-1:0]    rd_data;
    logic                wr_en;
    logic [NW-1:0]       wr_addr;
    logic [ROW_W-1:0]    wr_data;
    node_row_t           row;
    node_row_t           new_row;
    logic                row_wr;
    logic [LW-1:0]       lidx;
    logic                letter_oor;
    logic [NW-1:0]       child;
    logic                mark_here;
    logic                res_answer;
    logic                res_status;

    // Handshake
    assign items.ready     = (state_reg == S_IDLE);
    assign accept          = items.valid && items.ready;
    assign out_free        = !out_valid_reg || results.ready;
    assign results.valid   = out_valid_reg;
    assign results.answer  = out_answer_reg;
    assign results.status  = out_status_reg;

    // Read the row that holds the next link, or the current node's mark when
    // the walk stays put (no letter, or the word already stopped descending)
    assign rd_addr = ((items.no_letter || miss_reg || ovf_reg) && !at_root_reg) ?
                     mrow_reg : cursor_reg;

    // Letter decode for the captured item
    assign letter_oor = (32'(letter_reg) >= ALPHABET_SIZE);
    assign lidx       = LW'(letter_reg);
    assign row        = rd_data;
    assign child      = row.links[lidx];

    // Walk one letter and settle the word's result
    always_comb
    begin
        new_row          = row;
        row_wr           = 1'b0;
        cursor_next      = cursor_reg;
        at_root_next     = at_root_reg;
        mrow_next        = mrow_reg;
        mlet_next        = mlet_reg;
        miss_next        = miss_reg;
        ovf_next         = ovf_reg;
        nf_next          = nf_reg;
        root_mark_next   = root_mark_reg;
        res_answer       = 1'b0;
        res_status       = STATUS_OK;
        mark_here        = 1'b0;

        if (state_reg == S_EXEC)
        begin
            // Descend, allocating a node on insert where the link is null
            if (!nl_reg && !miss_reg && !ovf_reg)
            begin
                if (letter_oor)
                begin
                    miss_next = 1'b1;
                end
                else if (child != '0)
                begin
                    cursor_next  = child;
                    at_root_next = 1'b0;
                    mrow_next    = cursor_reg;
                    mlet_next    = lidx;
                end
                else if (op_reg != OP_INSERT)
                begin
                    miss_next = 1'b1;
                end
                else if (nf_reg == NFW'(NODE_COUNT))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    new_row.links[lidx] = nf_reg[NW-1:0];
                    row_wr              = 1'b1;
                    cursor_next         = nf_reg[NW-1:0];
                    at_root_next        = 1'b0;
                    mrow_next           = cursor_reg;
                    mlet_next           = lidx;
                    nf_next             = nf_reg + NFW'(1);
                end
            end

            // Finish the word on its last beat
            if (last_reg)
            begin
                mark_here = at_root_next ? root_mark_reg : new_row.marks[mlet_next];
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (ovf_next)
                        begin
                            res_status = STATUS_POOL_FULL;
                        end
                        else if (!miss_next)
                        begin
                            res_answer = 1'b1;
                            if (at_root_next)
                            begin
                                root_mark_next = 1'b1;
                            end
                            else
                            begin
                                new_row.marks[mlet_next] = 1'b1;
                                row_wr                   = 1'b1;
                            end
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!miss_next)
                        begin
                            res_answer = 1'b1;
                            if (at_root_next)
                            begin
                                root_mark_next = 1'b0;
                            end
                            else
                            begin
                                new_row.marks[mlet_next] = 1'b0;
                                row_wr                   = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        res_answer = !miss_next && mark_here;
                    end
                endcase

                // Return the walk to the root
                cursor_next  = '0;
                at_root_next = 1'b1;
                miss_next    = 1'b0;
                ovf_next     = 1'b0;
            end
        end
    end

    // Sequencer, item capture and output register
    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        op_next          = op_reg;
        letter_next      = letter_reg;
        nl_next          = nl_reg;
        last_next        = last_reg;
        row_addr_next    = row_addr_reg;
        pend_answer_next = pend_answer_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && !results.ready;
        out_answer_next  = out_answer_reg;
        out_status_next  = out_status_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + NW'(1);
                if (clr_reg == NW'(NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = items.op;
                    letter_next   = items.letter;
                    nl_next       = items.no_letter;
                    last_next     = items.is_last;
                    row_addr_next = rd_addr;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                pend_answer_next = res_answer;
                pend_status_next = res_status;
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_answer_next = res_answer;
                    out_status_next = res_status;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_answer_next = pend_answer_reg;
                    out_status_next = pend_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory write: clearing sweep or row update
    assign wr_en   = (state_reg == S_CLEAR) || row_wr;
    assign wr_addr = (state_reg == S_CLEAR) ? clr_reg : row_addr_reg;
    assign wr_data = (state_reg == S_CLEAR) ? '0 : ROW_W'(new_row);

    tde_node_ram
    #(
        .DEPTH (NODE_COUNT),
        .WIDTH (ROW_W)
    )
    u_node_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            nf_reg        <= NFW'(1);
            cursor_reg    <= '0;
            at_root_reg   <= 1'b1;
            mrow_reg      <= '0;
            mlet_reg      <= '0;
            miss_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            root_mark_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            nf_reg        <= nf_next;
            cursor_reg    <= cursor_next;
            at_root_reg   <= at_root_next;
            mrow_reg      <= mrow_next;
            mlet_reg      <= mlet_next;
            miss_reg      <= miss_next;
            ovf_reg       <= ovf_next;
            root_mark_reg <= root_mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        letter_reg      <= letter_next;
        nl_reg          <= nl_next;
        last_reg        <= last_next;
        row_addr_reg    <= row_addr_next;
        pend_answer_reg <= pend_answer_next;
        pend_status_reg <= pend_status_next;
        out_answer_reg  <= out_answer_next;
        out_status_reg  <= out_status_next;
    end

endmodule
